// ----- rtl/ttbl_pkg.sv -----
// Shared types, codes and helper functions of the timer table engine.
package ttbl_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int TIME_BITS   = 32;
  localparam int TAG_BITS    = 32;
  localparam int TMO_BITS    = 24;
  localparam int NT_BITS     = 25;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);

  // Stream payload widths.
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 3;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * ID_BITS + TAG_BITS + NT_BITS);

  // Largest reported remaining time.
  localparam logic [TMO_BITS-1:0] NT_MAX = '1;

  // Request kinds.
  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_CANCEL  = 2'd1;
  localparam logic [1:0] REQ_REFRESH = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [2:0] ST_BAD_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_EXPIRED     = 3'd4;
  localparam logic [2:0] ST_NONE        = 3'd5;

  // One timer slot as it travels along the row of cells.
  typedef struct packed {
    logic                 valid;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] expiry;
    logic [TAG_BITS-1:0]  tag;
  } slot_t;

  // Remaining time of a timer; an overdue timer reports zero.
  function automatic logic [TIME_BITS-1:0] time_left(input logic [TIME_BITS-1:0] expiry,
                                                     input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] d;
    d = expiry - now;
    if (d[TIME_BITS-1]) begin
      return '0;
    end
    return d;
  endfunction

  // Encode the nearest expiry: all ones when empty, else saturated.
  function automatic logic [NT_BITS-1:0] nt_encode(input logic any,
                                                   input logic [TIME_BITS-1:0] mn);
    if (!any) begin
      return '1;
    end
    if (mn > TIME_BITS'(NT_MAX)) begin
      return NT_BITS'(NT_MAX);
    end
    return NT_BITS'(mn);
  endfunction

endpackage

// ----- rtl/ttbl_cell.sv -----
// One cell of the timer ring: holds a slot and passes it to its neighbor on a shift.
module ttbl_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  ttbl_pkg::slot_t  d_i,
  output ttbl_pkg::slot_t  q_o
);

  logic                           valid_r;
  logic [ttbl_pkg::ID_BITS-1:0]   id_r;
  logic [ttbl_pkg::TIME_BITS-1:0] expiry_r;
  logic [ttbl_pkg::TAG_BITS-1:0]  tag_r;

  // The valid bit is control state and clears on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d_i.valid;
    end
  end

  // Timer payload moves with the valid bit.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r     <= d_i.id;
      expiry_r <= d_i.expiry;
      tag_r    <= d_i.tag;
    end
  end

  assign q_o = '{valid: valid_r, id: id_r, expiry: expiry_r, tag: tag_r};

endmodule

// ----- rtl/timer_table_engine_unit.sv -----
// Top level of the timer table engine: request stream, ring of timer cells, result stream.
//
// Usage: each input transaction on in_* is one request (add, cancel, refresh or a one
// millisecond tick), selected by in_tuser. Results leave on out_* with the status in
// out_tuser; out_tlast marks the final result of a request.
// The timers live in a ring of cells that rotates past a single head position, where
// all compares, updates and the nearest-expiry search happen; during a pass it moves
// by one slot a cycle unless a stalled output register holds it. A request takes one
// pass of the ring to look up ids, free slots and expired timers, then a decision
// state; add, cancel and refresh go on to a second pass that applies the change and
// finds the nearest expiry, and a tick that expires timers takes a second pass that
// emits them. A tick with nothing due answers after the decision state, with no second
// pass.
// in_tready is high only while no request is in progress; it does not depend on the
// output register, which holds a finished result until the receiver takes it.
// When the receiver stalls, the ring stops at the next result that needs the output
// register and resumes when it frees up; no result is dropped.
// Reset clears the clock, the id counter and all valid bits; the table starts empty.
module timer_table_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: timer_id [15:0], timeout_ms [39:16], user_tag [71:40]
  input  logic [ttbl_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: req_type [1:0]
  input  logic [ttbl_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: assigned_id [15:0], expired_id [31:16], expired_tag [63:32],
  //            next_timeout [88:64], zero padding [95:89]
  output logic [ttbl_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: status [2:0]
  output logic [ttbl_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast
);

  localparam int TB = ttbl_pkg::TIME_BITS;
  localparam int IB = ttbl_pkg::ID_BITS;
  localparam int SW = ttbl_pkg::SLOT_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [SW-1:0] LAST_STEP = SW'(ttbl_pkg::TABLE_DEPTH - 1);

  // Control registers.
  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [TB-1:0] now_r, now_nxt;
  logic [IB-1:0] next_id_r, next_id_nxt;

  // Request and scan registers.
  logic [1:0]                        req_r, req_nxt;
  logic [IB-1:0]                     key_id_r, key_id_nxt;
  logic [ttbl_pkg::TMO_BITS-1:0]     tmo_r, tmo_nxt;
  logic [ttbl_pkg::TAG_BITS-1:0]     tag_r, tag_nxt;
  logic                              found_r, found_nxt;
  logic [SW-1:0]                     match_idx_r, match_idx_nxt;
  logic                              free_found_r, free_found_nxt;
  logic [SW-1:0]                     free_idx_r, free_idx_nxt;
  logic                              any_exp_r, any_exp_nxt;
  logic [SW-1:0]                     last_exp_r, last_exp_nxt;
  logic                              min_any_r, min_any_nxt;
  logic [TB-1:0]                     min_r, min_nxt;
  logic                              tgt_en_r, tgt_en_nxt;
  logic [SW-1:0]                     tgt_idx_r, tgt_idx_nxt;
  logic [2:0]                        res_status_r, res_status_nxt;
  logic [IB-1:0]                     res_aid_r, res_aid_nxt;

  // Output register.
  logic [2:0]                        out_status_r, out_status_nxt;
  logic [IB-1:0]                     out_aid_r, out_aid_nxt;
  logic [IB-1:0]                     out_eid_r, out_eid_nxt;
  logic [ttbl_pkg::TAG_BITS-1:0]     out_etag_r, out_etag_nxt;
  logic [ttbl_pkg::NT_BITS-1:0]      out_nt_r, out_nt_nxt;
  logic                              out_last_r, out_last_nxt;

  // Ring of cells.
  ttbl_pkg::slot_t cell_q [ttbl_pkg::TABLE_DEPTH];
  ttbl_pkg::slot_t fb;
  logic            shift_en;

  // Head position signals.
  ttbl_pkg::slot_t head;
  ttbl_pkg::slot_t head_mod;
  logic [TB-1:0]   head_left;
  logic [TB-1:0]   mod_left;
  logic            head_exp;
  logic            at_target;
  logic            out_free;
  logic            last_step;
  logic [TB-1:0]   new_expiry;
  logic            in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign last_step = (step_r == LAST_STEP);

  // Cell i takes its neighbor's slot; the last cell takes the head after update.
  for (genvar i = 0; i < ttbl_pkg::TABLE_DEPTH; i++) begin : g_cell
    if (i == ttbl_pkg::TABLE_DEPTH - 1) begin : g_tail
      ttbl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_i      (fb),
        .q_o      (cell_q[i])
      );
    end else begin : g_body
      ttbl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_i      (cell_q[i+1]),
        .q_o      (cell_q[i])
      );
    end
  end

  // Head slot, its remaining time and the update applied in the second pass.
  always_comb begin
    head       = cell_q[0];
    head_left  = ttbl_pkg::time_left(head.expiry, now_r);
    head_exp   = head.valid && (head_left == '0);
    new_expiry = now_r + TB'(tmo_r);
    at_target  = (state_r == S_APPLY) && tgt_en_r && (step_r == tgt_idx_r);
    head_mod   = head;
    if (at_target) begin
      unique case (req_r)
        ttbl_pkg::REQ_ADD: begin
          head_mod = '{valid: 1'b1, id: key_id_r, expiry: new_expiry, tag: tag_r};
        end
        ttbl_pkg::REQ_CANCEL: begin
          head_mod.valid = 1'b0;
        end
        ttbl_pkg::REQ_REFRESH: begin
          head_mod.expiry = new_expiry;
        end
        default: begin
          head_mod = head;
        end
      endcase
    end
    mod_left = ttbl_pkg::time_left(head_mod.expiry, now_r);
  end

  // Sequencer, lookup, nearest-expiry search and output loading.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    now_nxt        = now_r;
    next_id_nxt    = next_id_r;
    req_nxt        = req_r;
    key_id_nxt     = key_id_r;
    tmo_nxt        = tmo_r;
    tag_nxt        = tag_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    any_exp_nxt    = any_exp_r;
    last_exp_nxt   = last_exp_r;
    min_any_nxt    = min_any_r;
    min_nxt        = min_r;
    tgt_en_nxt     = tgt_en_r;
    tgt_idx_nxt    = tgt_idx_r;
    res_status_nxt = res_status_r;
    res_aid_nxt    = res_aid_r;
    out_status_nxt = out_status_r;
    out_aid_nxt    = out_aid_r;
    out_eid_nxt    = out_eid_r;
    out_etag_nxt   = out_etag_r;
    out_nt_nxt     = out_nt_r;
    out_last_nxt   = out_last_r;
    fb             = head;
    shift_en       = 1'b0;

    // The receiver drains the output register.
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt        = in_tuser[1:0];
          key_id_nxt     = (in_tuser[1:0] == ttbl_pkg::REQ_ADD) ? next_id_r : in_tdata[15:0];
          tmo_nxt        = in_tdata[39:16];
          tag_nxt        = in_tdata[71:40];
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          any_exp_nxt    = 1'b0;
          min_any_nxt    = 1'b0;
          step_nxt       = '0;
          state_nxt      = S_SCAN;
          if (in_tuser[1:0] == ttbl_pkg::REQ_TICK) begin
            now_nxt = now_r + 1'b1;
          end
        end
      end

      S_SCAN: begin
        // First pass: id match, lowest free slot, expired timers.
        shift_en = 1'b1;
        if (head.valid && (head.id == key_id_r) && !found_r) begin
          found_nxt     = 1'b1;
          match_idx_nxt = step_r;
        end
        if (!head.valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = step_r;
        end
        if (req_r == ttbl_pkg::REQ_TICK) begin
          if (head_exp) begin
            any_exp_nxt  = 1'b1;
            last_exp_nxt = step_r;
          end else if (head.valid && (!min_any_r || head_left < min_r)) begin
            min_any_nxt = 1'b1;
            min_nxt     = head_left;
          end
        end
        step_nxt = last_step ? '0 : step_r + 1'b1;
        if (last_step) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        // Pick the slot to change and the status of the request.
        tgt_en_nxt     = 1'b0;
        tgt_idx_nxt    = match_idx_r;
        res_aid_nxt    = '0;
        res_status_nxt = ttbl_pkg::ST_OK;
        state_nxt      = S_APPLY;
        unique case (req_r)
          ttbl_pkg::REQ_ADD: begin
            if (found_r || free_found_r) begin
              tgt_en_nxt  = 1'b1;
              tgt_idx_nxt = found_r ? match_idx_r : free_idx_r;
              res_aid_nxt = key_id_r;
              next_id_nxt = key_id_r + 1'b1;
            end else begin
              res_status_nxt = ttbl_pkg::ST_FULL;
            end
          end
          ttbl_pkg::REQ_CANCEL: begin
            if (found_r) begin
              tgt_en_nxt = 1'b1;
            end else begin
              res_status_nxt = ttbl_pkg::ST_NOT_FOUND;
            end
          end
          ttbl_pkg::REQ_REFRESH: begin
            if (tmo_r == '0) begin
              res_status_nxt = ttbl_pkg::ST_BAD_TIMEOUT;
            end else if (found_r) begin
              tgt_en_nxt = 1'b1;
            end else begin
              res_status_nxt = ttbl_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            // A tick without expired timers answers at once.
            res_status_nxt = ttbl_pkg::ST_NONE;
            state_nxt      = any_exp_r ? S_EMIT : S_FIN;
          end
        endcase
        if (req_r != ttbl_pkg::REQ_TICK) begin
          min_any_nxt = 1'b0;
        end
      end

      S_APPLY: begin
        // Second pass: write the change back and search the nearest expiry.
        shift_en = 1'b1;
        fb       = head_mod;
        if (head_mod.valid && (!min_any_r || mod_left < min_r)) begin
          min_any_nxt = 1'b1;
          min_nxt     = mod_left;
        end
        step_nxt = last_step ? '0 : step_r + 1'b1;
        if (last_step) begin
          state_nxt = S_FIN;
        end
      end

      S_EMIT: begin
        // Second pass of a tick: hand out and drop each expired timer.
        if (head_exp) begin
          if (out_free) begin
            shift_en       = 1'b1;
            fb.valid       = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ttbl_pkg::ST_EXPIRED;
            out_aid_nxt    = '0;
            out_eid_nxt    = head.id;
            out_etag_nxt   = head.tag;
            out_nt_nxt     = ttbl_pkg::nt_encode(min_any_r, min_r);
            out_last_nxt   = (step_r == last_exp_r);
          end
        end else begin
          shift_en = 1'b1;
        end
        if (shift_en) begin
          step_nxt = last_step ? '0 : step_r + 1'b1;
          if (last_step) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_FIN: begin
        // Single result of the request.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_aid_nxt    = res_aid_r;
          out_eid_nxt    = '0;
          out_etag_nxt   = '0;
          out_nt_nxt     = ttbl_pkg::nt_encode(min_any_r, min_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      now_r       <= '0;
      next_id_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
    end
  end

  // Request, scan and result registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_id_r     <= key_id_nxt;
    tmo_r        <= tmo_nxt;
    tag_r        <= tag_nxt;
    found_r      <= found_nxt;
    match_idx_r  <= match_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    any_exp_r    <= any_exp_nxt;
    last_exp_r   <= last_exp_nxt;
    min_any_r    <= min_any_nxt;
    min_r        <= min_nxt;
    tgt_en_r     <= tgt_en_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    res_status_r <= res_status_nxt;
    res_aid_r    <= res_aid_nxt;
    out_status_r <= out_status_nxt;
    out_aid_r    <= out_aid_nxt;
    out_eid_r    <= out_eid_nxt;
    out_etag_r   <= out_etag_nxt;
    out_nt_r     <= out_nt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Result channel.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{ttbl_pkg::OUT_PAD_W{1'b0}}, out_nt_r, out_etag_r, out_eid_r, out_aid_r};

  // An accepted request always starts a fresh pass from the first slot.
  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_SCAN && step_r == '0)
    else $error("request did not start a scan at slot zero");

  // The ring is back in its home position whenever the block is idle.
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> step_r == '0)
    else $error("ring not aligned while idle");

  // Only expiry results can be followed by more results of the same request.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ttbl_pkg::ST_EXPIRED |-> out_tlast)
    else $error("non-expiry result without tlast");

  // Emitting only happens when the scan saw an expired timer.
  a_emit_has_exp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> any_exp_r)
    else $error("emit pass without expired timers");

endmodule
